FILE: rtl/rdq_pkg.sv
// Shared types and constants for the record deque with search.
package rdq_pkg;

  // Width of each record field on the ports.
  localparam int FLD_W = 16;
  // Width of the reported match position.
  localparam int POS_W = 6;
  // Fields per record.
  localparam int NFIELD = 6;

  typedef enum logic [1:0] {
    OP_POP_FRONT = 2'd0,
    OP_POP_BACK  = 2'd1,
    OP_INSERT    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [FLD_W-1:0] out_id;
    logic [FLD_W-1:0] out_age;
    logic [FLD_W-1:0] out_amount;
    logic [FLD_W-1:0] out_site;
    logic [FLD_W-1:0] out_food;
    logic [FLD_W-1:0] out_health;
    logic             was_empty;
    logic             found;
    logic [POS_W-1:0] position;
    logic             full_res;
  } rsp_t;

endpackage

FILE: rtl/rdq_if.sv
// Request and response channel interfaces for the record deque.
interface rdq_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic [rdq_pkg::FLD_W-1:0] rec_id;
  logic [rdq_pkg::FLD_W-1:0] rec_age;
  logic [rdq_pkg::FLD_W-1:0] rec_amount;
  logic [rdq_pkg::FLD_W-1:0] rec_site;
  logic [rdq_pkg::FLD_W-1:0] rec_food;
  logic [rdq_pkg::FLD_W-1:0] rec_health;

  modport source (
    output valid, op, rec_id, rec_age, rec_amount, rec_site, rec_food, rec_health,
    input  ready
  );
  modport sink (
    input  valid, op, rec_id, rec_age, rec_amount, rec_site, rec_food, rec_health,
    output ready
  );
endinterface

interface rdq_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [rdq_pkg::FLD_W-1:0] out_id;
  logic [rdq_pkg::FLD_W-1:0] out_age;
  logic [rdq_pkg::FLD_W-1:0] out_amount;
  logic [rdq_pkg::FLD_W-1:0] out_site;
  logic [rdq_pkg::FLD_W-1:0] out_food;
  logic [rdq_pkg::FLD_W-1:0] out_health;
  logic                      was_empty;
  logic                      found;
  logic [rdq_pkg::POS_W-1:0] position;
  logic                      full_res;

  modport source (
    output valid, out_id, out_age, out_amount, out_site, out_food, out_health,
           was_empty, found, position, full_res,
    input  ready
  );
  modport sink (
    input  valid, out_id, out_age, out_amount, out_site, out_food, out_health,
           was_empty, found, position, full_res,
    output ready
  );
endinterface

FILE: rtl/rdq_mem.sv
// Record store: one write port, one registered read port.
module rdq_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/record_deque_with_search.sv
// Record deque with linear search: sequencer, pointers and result register.
//
//  channel | dir | payload                                              | done when
//  --------+-----+------------------------------------------------------+------------------
//  req     | in  | op, rec_id, rec_age, rec_amount, rec_site, rec_food, | valid & ready
//          |     | rec_health                                           |
//  resp    | out | out_id..out_health, was_empty, found, position,      | valid & ready
//          |     | full_res                                             |
//
// A pop goes from acceptance through the pop state to the output state; an
// empty pop or an unused op goes straight to the output state. Insert-or-find
// walks the store through the single memory read port, one entry per cycle.
// Reset clears the front pointer, occupancy, the sequencer and response valid
// only; the record memory is not cleared, and only written entries are used.
// req.ready is high in the idle state; a response waiting on resp does not
// block the next request until that request's own response is ready to load.
module record_deque_with_search #(
  parameter int DEPTH      = 64,
  parameter int FIELD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  rdq_req_if.sink   req,
  rdq_rsp_if.source resp
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int REC_W = rdq_pkg::NFIELD * FIELD_BITS;

  rdq_pkg::state_t state, state_next;

  logic [PTR_W-1:0] front;
  logic [CNT_W-1:0] occ;
  logic [PTR_W-1:0] scan_addr;  // next entry to read during a search
  logic [PTR_W-1:0] cmp_pos;    // position of the entry in mem_rdata
  logic [REC_W-1:0] rec;        // record under search
  rdq_pkg::rsp_t    res;        // result being built
  rdq_pkg::rsp_t    res_init;   // result as it starts on acceptance
  rdq_pkg::rsp_t    rsp_q;      // result shown on resp
  logic             rsp_vld;

  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [REC_W-1:0] mem_wdata;
  logic [PTR_W-1:0] mem_raddr;
  logic [REC_W-1:0] mem_rdata;

  logic             accept;
  logic             out_free;
  logic             is_match;
  logic             is_last;
  logic             is_full;
  logic             pop_empty;
  logic [PTR_W-1:0] tail_ptr;
  logic [PTR_W-1:0] back_ptr;
  logic [REC_W-1:0] req_rec;

  // Circular index: sum is below 2*DEPTH, so one subtract wraps it.
  function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    begin
      t = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
      return t[PTR_W-1:0];
    end
  endfunction

  function automatic logic [PTR_W-1:0] incr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Field j of a packed record, id first, widened or cut to port width.
  function automatic logic [rdq_pkg::FLD_W-1:0] field(input logic [REC_W-1:0] r,
                                                      input int j);
    return rdq_pkg::FLD_W'(r[(rdq_pkg::NFIELD - 1 - j) * FIELD_BITS +: FIELD_BITS]);
  endfunction

  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp_vld || resp.ready;
  assign is_match  = (mem_rdata == rec);
  assign is_last   = (CNT_W'(cmp_pos) + CNT_W'(1)) == occ;
  assign is_full   = (occ == CNT_W'(DEPTH));
  assign tail_ptr  = wrap(SUM_W'(front) + SUM_W'(occ));
  assign back_ptr  = wrap(SUM_W'(front) + SUM_W'(occ) - SUM_W'(1));
  assign pop_empty = (req.op == rdq_pkg::OP_POP_FRONT || req.op == rdq_pkg::OP_POP_BACK)
                     && occ == '0;

  // Input fields are kept at FIELD_BITS bits.
  assign req_rec = {FIELD_BITS'(req.rec_id),   FIELD_BITS'(req.rec_age),
                    FIELD_BITS'(req.rec_amount), FIELD_BITS'(req.rec_site),
                    FIELD_BITS'(req.rec_food), FIELD_BITS'(req.rec_health)};

  // Fresh result: all zero, was_empty set for a pop on an empty store.
  always_comb begin
    res_init           = '0;
    res_init.was_empty = pop_empty;
  end

  rdq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (REC_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rdq_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.op) inside
            rdq_pkg::OP_POP_FRONT, rdq_pkg::OP_POP_BACK:
              state_next = (occ != '0) ? rdq_pkg::ST_POP : rdq_pkg::ST_OUT;
            rdq_pkg::OP_INSERT:
              state_next = (occ != '0) ? rdq_pkg::ST_SCAN : rdq_pkg::ST_OUT;
            default:
              state_next = rdq_pkg::ST_OUT;
          endcase
        end
      end
      rdq_pkg::ST_POP: state_next = rdq_pkg::ST_OUT;
      rdq_pkg::ST_SCAN: begin
        if (is_match || is_last) begin
          state_next = rdq_pkg::ST_OUT;
        end
      end
      rdq_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = rdq_pkg::ST_IDLE;
        end
      end
      default: state_next = rdq_pkg::ST_IDLE;
    endcase
  end

  // Handshake and memory controls.
  always_comb begin
    req.ready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = tail_ptr;
    mem_wdata = rec;
    mem_raddr = front;
    unique case (state)
      rdq_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        mem_raddr = (req.op == rdq_pkg::OP_POP_BACK) ? back_ptr : front;
        // first insert into an empty store: no search needed
        if (accept && req.op == rdq_pkg::OP_INSERT && occ == '0) begin
          mem_we    = 1'b1;
          mem_waddr = front;
          mem_wdata = req_rec;
        end
      end
      rdq_pkg::ST_SCAN: begin
        mem_raddr = scan_addr;
        if (!is_match && is_last && !is_full) begin
          mem_we = 1'b1;
        end
      end
      rdq_pkg::ST_POP, rdq_pkg::ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      occ   <= '0;
    end else begin
      case (state)
        rdq_pkg::ST_IDLE: begin
          if (accept && occ != '0) begin
            if (req.op == rdq_pkg::OP_POP_FRONT) begin
              front <= incr(front);
              occ   <= occ - CNT_W'(1);
            end else if (req.op == rdq_pkg::OP_POP_BACK) begin
              occ   <= occ - CNT_W'(1);
            end
          end else if (accept && req.op == rdq_pkg::OP_INSERT) begin
            occ <= CNT_W'(1);
          end
        end
        rdq_pkg::ST_SCAN: begin
          if (!is_match && is_last && !is_full) begin
            occ <= occ + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Search walk and result build-up.
  always_ff @(posedge clk) begin
    case (state)
      rdq_pkg::ST_IDLE: begin
        if (accept) begin
          rec       <= req_rec;
          res       <= res_init;
          cmp_pos   <= '0;
          scan_addr <= incr(front);
        end
      end
      rdq_pkg::ST_POP: begin
        res.out_id     <= field(mem_rdata, 0);
        res.out_age    <= field(mem_rdata, 1);
        res.out_amount <= field(mem_rdata, 2);
        res.out_site   <= field(mem_rdata, 3);
        res.out_food   <= field(mem_rdata, 4);
        res.out_health <= field(mem_rdata, 5);
      end
      rdq_pkg::ST_SCAN: begin
        if (is_match) begin
          res.found    <= 1'b1;
          res.position <= rdq_pkg::POS_W'(cmp_pos);
        end else if (is_last) begin
          res.full_res <= is_full;
        end else begin
          cmp_pos   <= cmp_pos + PTR_W'(1);
          scan_addr <= incr(scan_addr);
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (state == rdq_pkg::ST_OUT && out_free) begin
      rsp_vld <= 1'b1;
    end else if (resp.ready) begin
      rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rdq_pkg::ST_OUT && out_free) begin
      rsp_q <= res;
    end
  end

  assign resp.valid      = rsp_vld;
  assign resp.out_id     = rsp_q.out_id;
  assign resp.out_age    = rsp_q.out_age;
  assign resp.out_amount = rsp_q.out_amount;
  assign resp.out_site   = rsp_q.out_site;
  assign resp.out_food   = rsp_q.out_food;
  assign resp.out_health = rsp_q.out_health;
  assign resp.was_empty  = rsp_q.was_empty;
  assign resp.found      = rsp_q.found;
  assign resp.position   = rsp_q.position;
  assign resp.full_res   = rsp_q.full_res;

endmodule
